### rtl/mae_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mae_pkg: shared types and constants of the matrix add / multiply engine
// Item payload structs, mode and status codes, register indexes and the
// operation codes of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package mae_pkg;

   // Default sizing, handed to the top level parameters
   localparam int MAX_DIM_DEF    = 8;
   localparam int DATA_WIDTH_DEF = 32;

   // Fixed field widths of the item payloads
   localparam int CFG_W       = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int ROW_W       = 3;
   localparam int COL_W       = 3;
   localparam int VALUE_W     = 32;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] REG_A_ROWS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_A_COLS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_B_ROWS = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_B_COLS = 2'd3;

   typedef enum logic [1:0] {
      MODE_LOAD_A = 2'd0,
      MODE_LOAD_B = 2'd1,
      MODE_ADD    = 2'd2,
      MODE_MUL    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_MISMATCH = 2'd1,
      STATUS_BAD_IDX  = 2'd2,
      STATUS_EMPTY    = 2'd3
   } status_type;

   // Operations of the shared multiply / add unit
   typedef enum logic [2:0] {
      MAC_HOLD   = 3'd0,
      MAC_CLEAR  = 3'd1,
      MAC_SUM    = 3'd2,
      MAC_MUL_LL = 3'd3,
      MAC_MUL_LH = 3'd4,
      MAC_MUL_HL = 3'd5,
      MAC_ACC_HI = 3'd6
   } mac_op_type;

   typedef struct packed {
      mode_type                   mode;
      logic [ROW_W-1:0]           row_index;
      logic [COL_W-1:0]           col_index;
      logic signed [VALUE_W-1:0]  load_value;
   } req_payload_type;

   typedef struct packed {
      logic [ROW_W-1:0]           out_row;
      logic [COL_W-1:0]           out_col;
      logic signed [VALUE_W-1:0]  out_value;
      status_type                 status;
      logic                       last;
   } rsp_payload_type;

endpackage

### rtl/mae_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mae_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mae_ram import mae_pkg::*; #(
   parameter  int WIDTH  = DATA_WIDTH_DEF,
   parameter  int DEPTH  = MAX_DIM_DEF * MAX_DIM_DEF,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on enable, register the read word every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/mae_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mae_mac: shared multiply / add unit
// One half-width multiplier and one adder. A full product term is built from
// three partial products (low x low, low x high, high x low), which is all
// that counts modulo 2^DATA_WIDTH, and folded into the accumulator.
// ----------------------------------------------------------------------------
module mae_mac import mae_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  mac_op_type            op,
   input  logic [DATA_WIDTH-1:0] a_operand,
   input  logic [DATA_WIDTH-1:0] b_operand,
   output logic [DATA_WIDTH-1:0] acc
);

   localparam int HALF_W = (DATA_WIDTH + 1) / 2;
   localparam int PROD_W = 2 * HALF_W;

   logic [HALF_W-1:0]     a_lo, a_hi, b_lo, b_hi;
   logic [HALF_W-1:0]     mul_x, mul_y;
   logic [PROD_W-1:0]     product;
   logic [DATA_WIDTH-1:0] add_x, add_y, sum;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;

   // Split operands into halves
   assign a_lo = a_operand[HALF_W-1:0];
   assign b_lo = b_operand[HALF_W-1:0];
   assign a_hi = HALF_W'(a_operand[DATA_WIDTH-1:HALF_W]);
   assign b_hi = HALF_W'(b_operand[DATA_WIDTH-1:HALF_W]);

   // Select the multiplier inputs for this partial product
   always_comb begin
      unique case (op)
         MAC_MUL_LH: begin
            mul_x = a_lo;
            mul_y = b_hi;
         end
         MAC_MUL_HL: begin
            mul_x = a_hi;
            mul_y = b_lo;
         end
         default: begin
            mul_x = a_lo;
            mul_y = b_lo;
         end
      endcase
   end

   assign product = PROD_W'(mul_x) * PROD_W'(mul_y);

   // Select the adder inputs: element sum or accumulate of the last product
   always_comb begin
      add_x = acc_ff;
      add_y = '0;
      unique case (op)
         MAC_SUM: begin
            add_x = a_operand;
            add_y = b_operand;
         end
         MAC_MUL_LH: add_y = DATA_WIDTH'(prod_ff);
         MAC_MUL_HL, MAC_ACC_HI: add_y = DATA_WIDTH'(prod_ff) << HALF_W;
         default: add_y = '0;
      endcase
   end

   assign sum = add_x + add_y;

   // Next accumulator and product register
   always_comb begin
      acc_in  = acc_ff;
      prod_in = prod_ff;
      unique case (op)
         MAC_CLEAR:  acc_in = '0;
         MAC_SUM:    acc_in = sum;
         MAC_MUL_LL: prod_in = product;
         MAC_MUL_LH, MAC_MUL_HL: begin
            acc_in  = sum;
            prod_in = product;
         end
         MAC_ACC_HI: acc_in = sum;
         default: begin
            acc_in  = acc_ff;
            prod_in = prod_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign acc = acc_ff;

endmodule

### rtl/matrix_add_multiply_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_add_multiply_engine_top: integer matrix add / multiply engine
// Holds matrices A and B and streams their sum or product element by element.
// ----------------------------------------------------------------------------
// Usage:
//  - Set the matrix sizes on the csr_ port (a_rows, a_cols, b_rows, b_cols),
//    values above MAX_DIM act as MAX_DIM. Write them only while idle.
//  - req_ items: load A, load B, add or multiply. A load inside the size is
//    taken, giving no result; loads stream one per cycle unless rsp_ stalls.
//    A load outside the size gives one result with the invalid-index status.
//  - Add and multiply stream results on rsp_ in row-major order, the final
//    one marked last. A shape mismatch or an empty result gives a single
//    status result instead.
//  - Each add element needs a registered store read and one sum; each product
//    term needs a registered store read and three passes through the one
//    half-width multiplier. A zero inner size gives all-zero elements.
//  - req_ready is low while a compute item runs and whenever the result
//    register is full and not being taken, so a stalled receiver holds the
//    sequencer back without losing an item.
//  - Reset clears the sizes, the sequencer and both stores (through per-entry
//    valid bits, so no clearing pass is needed).
// ----------------------------------------------------------------------------
module matrix_add_multiply_engine_top import mae_pkg::*; #(
   parameter int MAX_DIM    = MAX_DIM_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_write_data
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam logic [CFG_W-1:0] DIM_MAX = CFG_W'(MAX_DIM);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SUM,
      ST_MUL_LL,
      ST_MUL_LH,
      ST_MUL_HL,
      ST_MUL_HI,
      ST_EMIT
   } state_type;

   function automatic logic [CFG_W-1:0] sat_dim(input logic [CFG_W-1:0] r);
      return (r > DIM_MAX) ? DIM_MAX : r;
   endfunction

   // Configuration registers
   logic [CFG_W-1:0] a_rows_ff, a_cols_ff, b_rows_ff, b_cols_ff;

   // Sequencer state
   state_type        state_ff, state_in;
   logic             mul_mode_ff, mul_mode_in;
   logic [CFG_W-1:0] nr_ff, nr_in, nc_ff, nc_in, nk_ff, nk_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   // Store valid bits and registered read flags
   logic [DEPTH-1:0] a_vld_ff, b_vld_ff;
   logic             a_rd_vld_ff, b_rd_vld_ff;

   logic [CFG_W-1:0]      ar, ac, br, bc, res_cols, load_rows, load_cols;
   logic                  req_fire, slot_free, load_ok, shape_bad, last_elem;
   logic                  a_wr_en, b_wr_en;
   logic [ADDR_W-1:0]     load_addr, a_rd_addr, b_rd_addr;
   logic [DATA_WIDTH-1:0] load_data, a_rd_data, b_rd_data, a_operand, b_operand;
   logic [DATA_WIDTH-1:0] acc;
   mac_op_type            mac_op;

   // Hold configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff <= '0;
         a_cols_ff <= '0;
         b_rows_ff <= '0;
         b_cols_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_A_ROWS: a_rows_ff <= csr_write_data;
            REG_A_COLS: a_cols_ff <= csr_write_data;
            REG_B_ROWS: b_rows_ff <= csr_write_data;
            REG_B_COLS: b_cols_ff <= csr_write_data;
            default:    a_rows_ff <= a_rows_ff;
         endcase
      end
   end

   assign ar = sat_dim(a_rows_ff);
   assign ac = sat_dim(a_cols_ff);
   assign br = sat_dim(b_rows_ff);
   assign bc = sat_dim(b_cols_ff);

   // Decode the incoming item
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire  = req_valid && req_ready;

   assign load_rows = (req_payload.mode == MODE_LOAD_B) ? br : ar;
   assign load_cols = (req_payload.mode == MODE_LOAD_B) ? bc : ac;
   assign load_ok   = (CFG_W'(req_payload.row_index) < load_rows) &&
                      (CFG_W'(req_payload.col_index) < load_cols);
   assign load_addr = ADDR_W'(32'(req_payload.row_index) * MAX_DIM +
                              32'(req_payload.col_index));
   assign load_data = DATA_WIDTH'(req_payload.load_value);
   assign shape_bad = (req_payload.mode == MODE_ADD) ? ((ar != br) || (ac != bc))
                                                     : (ac != br);
   assign res_cols  = (req_payload.mode == MODE_ADD) ? ac : bc;

   // Store addresses of the current term
   assign a_rd_addr = mul_mode_ff ? ADDR_W'(32'(i_ff) * MAX_DIM + 32'(k_ff))
                                  : ADDR_W'(32'(i_ff) * MAX_DIM + 32'(j_ff));
   assign b_rd_addr = mul_mode_ff ? ADDR_W'(32'(k_ff) * MAX_DIM + 32'(j_ff))
                                  : ADDR_W'(32'(i_ff) * MAX_DIM + 32'(j_ff));

   assign last_elem = (CFG_W'(i_ff) + 1'b1 == nr_ff) && (CFG_W'(j_ff) + 1'b1 == nc_ff);

   // Sequencer next state
   always_comb begin
      state_in       = state_ff;
      mul_mode_in    = mul_mode_ff;
      nr_in          = nr_ff;
      nc_in          = nc_ff;
      nk_in          = nk_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      k_in           = k_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      mac_op         = MAC_HOLD;
      a_wr_en        = 1'b0;
      b_wr_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            mac_op = MAC_CLEAR;
            if (req_fire) begin
               unique case (req_payload.mode)
                  MODE_LOAD_A, MODE_LOAD_B: begin
                     if (load_ok) begin
                        a_wr_en = (req_payload.mode == MODE_LOAD_A);
                        b_wr_en = (req_payload.mode == MODE_LOAD_B);
                     end else begin
                        rsp_valid_in   = 1'b1;
                        rsp_payload_in = '{out_row: req_payload.row_index,
                                           out_col: req_payload.col_index,
                                           out_value: '0,
                                           status: STATUS_BAD_IDX,
                                           last: 1'b1};
                     end
                  end
                  MODE_ADD, MODE_MUL: begin
                     if (shape_bad || ar == '0 || res_cols == '0) begin
                        rsp_valid_in   = 1'b1;
                        rsp_payload_in = '{out_row: '0, out_col: '0, out_value: '0,
                                           status: shape_bad ? STATUS_MISMATCH
                                                             : STATUS_EMPTY,
                                           last: 1'b1};
                     end else begin
                        mul_mode_in = (req_payload.mode == MODE_MUL);
                        nr_in       = ar;
                        nc_in       = res_cols;
                        nk_in       = ac;
                        i_in        = '0;
                        j_in        = '0;
                        k_in        = '0;
                        state_in    = ST_FETCH;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_FETCH: begin
            if (!mul_mode_ff) begin
               state_in = ST_SUM;
            end else if (nk_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_MUL_LL;
            end
         end
         ST_SUM: begin
            mac_op   = MAC_SUM;
            state_in = ST_EMIT;
         end
         ST_MUL_LL: begin
            mac_op   = MAC_MUL_LL;
            state_in = ST_MUL_LH;
         end
         ST_MUL_LH: begin
            mac_op   = MAC_MUL_LH;
            state_in = ST_MUL_HL;
         end
         ST_MUL_HL: begin
            mac_op   = MAC_MUL_HL;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            mac_op = MAC_ACC_HI;
            // advance to the next inner term or finish the element
            if (CFG_W'(k_ff) + 1'b1 < nk_ff) begin
               k_in     = k_ff + 1'b1;
               state_in = ST_FETCH;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = '{out_row: ROW_W'(i_ff), out_col: COL_W'(j_ff),
                                  out_value: VALUE_W'(signed'(acc)),
                                  status: STATUS_OK, last: last_elem};
               mac_op = MAC_CLEAR;
               k_in   = '0;
               if (last_elem) begin
                  state_in = ST_IDLE;
               end else if (CFG_W'(j_ff) + 1'b1 == nc_ff) begin
                  j_in     = '0;
                  i_in     = i_ff + 1'b1;
                  state_in = ST_FETCH;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_FETCH;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold sequencer state and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mul_mode_ff    <= mul_mode_in;
      nr_ff          <= nr_in;
      nc_ff          <= nc_in;
      nk_ff          <= nk_in;
      i_ff           <= i_in;
      j_ff           <= j_in;
      k_ff           <= k_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Track written entries; an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= '0;
         b_vld_ff <= '0;
      end else begin
         if (a_wr_en) begin
            a_vld_ff[load_addr] <= 1'b1;
         end
         if (b_wr_en) begin
            b_vld_ff[load_addr] <= 1'b1;
         end
      end
      a_rd_vld_ff <= a_vld_ff[a_rd_addr];
      b_rd_vld_ff <= b_vld_ff[b_rd_addr];
   end

   mae_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_a_store (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (load_addr),
      .wr_data (load_data),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   mae_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_b_store (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (load_addr),
      .wr_data (load_data),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   assign a_operand = a_rd_vld_ff ? a_rd_data : '0;
   assign b_operand = b_rd_vld_ff ? b_rd_data : '0;

   mae_mac #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mac (
      .clock     (clock),
      .op        (mac_op),
      .a_operand (a_operand),
      .b_operand (b_operand),
      .acc       (acc)
   );

endmodule

### rtl/mae_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mae_checker: port-level checks of the matrix engine
// Watches the result channel and the input ready of the top level.
// ----------------------------------------------------------------------------
module mae_checker import mae_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // Hold a stalled result item unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result item changed while stalled");

   // Every status item closes its input item
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != STATUS_OK |-> rsp_payload.last)
      else $error("status item not marked last");

   // Shape and empty status items carry zero position and value
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == STATUS_MISMATCH ||
                    rsp_payload.status == STATUS_EMPTY)
      |-> rsp_payload.out_row == '0 && rsp_payload.out_col == '0 &&
          rsp_payload.out_value == '0)
      else $error("status item with non-zero fields");

   // Drop ready while a stream is still running
   a_busy_mid_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last |-> !req_ready)
      else $error("input ready in the middle of a result stream");

endmodule

bind matrix_add_multiply_engine_top mae_checker u_mae_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

### tb/matrix_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_result_checker: result predictor and comparator of the matrix engine
// Watches the request, result and register ports of the engine. It keeps its
// own copy of the sizes and of both matrices, works out the result elements
// of every accepted request item and compares each accepted result item with
// the oldest outstanding element.
// ----------------------------------------------------------------------------
module matrix_result_checker import mae_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_payload_type        req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_payload_type        rsp_payload,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_write_data,
   output int                     mismatch_count,
   output int                     pending_count
);

   // Shadow copy of the sizes and of both matrices
   logic [CFG_W-1:0]   size_a_rows, size_a_cols, size_b_rows, size_b_cols;
   logic [VALUE_W-1:0] elem_a [MAX_DIM_DEF][MAX_DIM_DEF];
   logic [VALUE_W-1:0] elem_b [MAX_DIM_DEF][MAX_DIM_DEF];

   // Result elements still owed by the engine, oldest first
   rsp_payload_type    owed_elements [$];

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   // Sizes above the store dimension act as the store dimension
   function automatic int used_dim(input logic [CFG_W-1:0] size);
      return (size > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(size);
   endfunction

   // Apply one request item to the shadow state and queue what it yields
   task automatic predict_matrix_item(input req_payload_type item);
      int              a_r, a_c, b_r, b_c, n_rows, n_cols, lim_r, lim_c;
      bit              shape_ok;
      logic [VALUE_W-1:0] acc;
      rsp_payload_type elem;
      a_r  = used_dim(size_a_rows);
      a_c  = used_dim(size_a_cols);
      b_r  = used_dim(size_b_rows);
      b_c  = used_dim(size_b_cols);
      elem = '0;
      case (item.mode)
         MODE_LOAD_A, MODE_LOAD_B: begin
            lim_r = (item.mode == MODE_LOAD_A) ? a_r : b_r;
            lim_c = (item.mode == MODE_LOAD_A) ? a_c : b_c;
            if (int'(item.row_index) < lim_r && int'(item.col_index) < lim_c) begin
               if (item.mode == MODE_LOAD_A)
                  elem_a[item.row_index][item.col_index] = item.load_value;
               else
                  elem_b[item.row_index][item.col_index] = item.load_value;
            end else begin
               // Out-of-range load: echo the indices, store nothing
               elem.out_row = item.row_index;
               elem.out_col = item.col_index;
               elem.status  = STATUS_BAD_IDX;
               elem.last    = 1'b1;
               owed_elements.push_back(elem);
            end
         end
         default: begin
            n_rows = a_r;
            if (item.mode == MODE_ADD) begin
               shape_ok = (a_r == b_r) && (a_c == b_c);
               n_cols   = a_c;
            end else begin
               shape_ok = (a_c == b_r);
               n_cols   = b_c;
            end
            elem.last = 1'b1;
            if (!shape_ok) begin
               elem.status = STATUS_MISMATCH;
               owed_elements.push_back(elem);
            end else if (n_rows == 0 || n_cols == 0) begin
               elem.status = STATUS_EMPTY;
               owed_elements.push_back(elem);
            end else begin
               // Stream the result row-major, wrapping at the value width
               for (int i = 0; i < n_rows; i++) begin
                  for (int j = 0; j < n_cols; j++) begin
                     if (item.mode == MODE_ADD) begin
                        acc = elem_a[i][j] + elem_b[i][j];
                     end else begin
                        acc = '0;
                        for (int k = 0; k < a_c; k++)
                           acc = acc + elem_a[i][k] * elem_b[k][j];
                     end
                     elem.out_row   = ROW_W'(i);
                     elem.out_col   = COL_W'(j);
                     elem.out_value = acc;
                     elem.status    = STATUS_OK;
                     elem.last      = (i == n_rows - 1) && (j == n_cols - 1);
                     owed_elements.push_back(elem);
                  end
               end
            end
         end
      endcase
   endtask

   // Compare one accepted result item with the oldest owed element
   task automatic compare_result(input rsp_payload_type got);
      rsp_payload_type want;
      if (owed_elements.size() == 0) begin
         mismatch_count++;
         $display({"%0t: unexpected result item: expected none, ",
                   "got row %0d col %0d value %0d status %0d last %0d"},
                  $time, got.out_row, got.out_col, got.out_value, got.status,
                  got.last);
      end else begin
         want = owed_elements.pop_front();
         if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
             got.out_value !== want.out_value || got.status !== want.status ||
             got.last !== want.last) begin
            mismatch_count++;
            $display({"%0t: result mismatch: ",
                      "expected row %0d col %0d value %0d status %0d last %0d, ",
                      "got row %0d col %0d value %0d status %0d last %0d"},
                     $time, want.out_row, want.out_col, want.out_value, want.status,
                     want.last, got.out_row, got.out_col, got.out_value, got.status,
                     got.last);
         end
      end
   endtask

   // Sample all ports at the clock edge; results first, so a result never
   // pairs with an item accepted on the same edge, and register writes last,
   // so an item accepted on the same edge still sees the old sizes
   always @(posedge clock) begin
      if (reset) begin
         size_a_rows = '0;
         size_a_cols = '0;
         size_b_rows = '0;
         size_b_cols = '0;
         for (int i = 0; i < MAX_DIM_DEF; i++) begin
            for (int j = 0; j < MAX_DIM_DEF; j++) begin
               elem_a[i][j] = '0;
               elem_b[i][j] = '0;
            end
         end
         owed_elements.delete();
      end else begin
         if (rsp_valid && rsp_ready)
            compare_result(rsp_payload);
         if (req_valid && req_ready)
            predict_matrix_item(req_payload);
         if (csr_write_enable) begin
            case (csr_index)
               REG_A_ROWS: size_a_rows = csr_write_data;
               REG_A_COLS: size_a_cols = csr_write_data;
               REG_B_ROWS: size_b_rows = csr_write_data;
               REG_B_COLS: size_b_cols = csr_write_data;
               default: ;
            endcase
         end
      end
      pending_count = owed_elements.size();
   end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the matrix add / multiply engine
// Drives a directed set of loads, adds and multiplies over the size corners,
// then random phases of loads and computes under changing sizes, with random
// gaps on the request side and random stalls on the result side. Checking is
// done by matrix_result_checker beside the engine.
// ----------------------------------------------------------------------------
module tb;
   import mae_pkg::*;

   localparam int CYCLE_LIMIT     = 4000000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int END_CYCLES      = 50;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 13;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = REG_A_ROWS;
   logic [CFG_W-1:0]       csr_write_data = '0;

   int mismatch_count;
   int pending_count;
   int cycle_count = 0;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;

   // Stimulus working variables
   int              phase, shape, n_compute, rows_in_use, cols_in_use, row, col;
   logic [CFG_W-1:0] sz_ar, sz_ac, sz_br, sz_bc;
   logic [VALUE_W-1:0] value;
   bit              to_b;
   req_payload_type item;

   matrix_add_multiply_engine_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   matrix_result_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic req_payload_type make_item(input mode_type mode, input int r,
                                                 input int c, input logic [VALUE_W-1:0] v);
      req_payload_type it;
      it.mode       = mode;
      it.row_index  = ROW_W'(r);
      it.col_index  = COL_W'(c);
      it.load_value = v;
      return it;
   endfunction

   // Offer one item, with a random gap first; hold it until accepted
   task automatic send_req(input req_payload_type it);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= it;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid, wait for every owed result, then let a trailing load finish
   task automatic wait_until_idle(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CFG_W-1:0] v);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= v;
      @(posedge clock);
   endtask

   task automatic set_sizes(input logic [CFG_W-1:0] ar, input logic [CFG_W-1:0] ac,
                            input logic [CFG_W-1:0] br, input logic [CFG_W-1:0] bc);
      write_reg(REG_A_ROWS, ar);
      write_reg(REG_A_COLS, ac);
      write_reg(REG_B_ROWS, br);
      write_reg(REG_B_COLS, bc);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sizes at reset: empty add and multiply, loads all out of range
      send_req(make_item(MODE_ADD, 0, 0, 32'h0));
      send_req(make_item(MODE_MUL, 0, 0, 32'h0));
      send_req(make_item(MODE_LOAD_A, 7, 7, 32'h7FFF_FFFF));
      send_req(make_item(MODE_LOAD_B, 0, 0, 32'h8000_0000));

      // Oversized registers saturate to full matrices; corner values
      wait_until_idle(SETTLE_CYCLES);
      set_sizes(4'hF, 4'hF, 4'hF, 4'hF);
      send_req(make_item(MODE_LOAD_A, 7, 7, 32'h7FFF_FFFF));
      send_req(make_item(MODE_LOAD_A, 0, 0, 32'h8000_0000));
      send_req(make_item(MODE_LOAD_A, 0, 7, 32'hFFFF_FFFF));
      send_req(make_item(MODE_LOAD_B, 7, 0, 32'hFFFF_FFFF));
      send_req(make_item(MODE_LOAD_B, 0, 0, 32'h7FFF_FFFF));
      send_req(make_item(MODE_LOAD_B, 7, 7, 32'h8000_0000));
      send_req(make_item(MODE_ADD, 7, 7, 32'hFFFF_FFFF));
      send_req(make_item(MODE_MUL, 7, 7, 32'hFFFF_FFFF));

      // Zero inner size: all-zero product; add and loads rejected
      wait_until_idle(SETTLE_CYCLES);
      set_sizes(4'd2, 4'd0, 4'd0, 4'd3);
      send_req(make_item(MODE_MUL, 0, 0, 32'h0));
      send_req(make_item(MODE_ADD, 0, 0, 32'h0));
      send_req(make_item(MODE_LOAD_A, 0, 0, 32'd5));
      send_req(make_item(MODE_LOAD_B, 0, 0, 32'd5));

      // Add fits, multiply does not; loads just inside and just outside
      wait_until_idle(SETTLE_CYCLES);
      set_sizes(4'd3, 4'd2, 4'd3, 4'd2);
      send_req(make_item(MODE_LOAD_A, 2, 1, 32'd3));
      send_req(make_item(MODE_LOAD_B, 2, 1, -32'sd7));
      send_req(make_item(MODE_LOAD_A, 3, 0, 32'd1));
      send_req(make_item(MODE_LOAD_B, 0, 2, 32'd1));
      send_req(make_item(MODE_ADD, 0, 0, 32'h0));
      send_req(make_item(MODE_MUL, 0, 0, 32'h0));

      // Matching shapes with no rows
      wait_until_idle(SETTLE_CYCLES);
      set_sizes(4'd0, 4'd3, 4'd0, 4'd3);
      send_req(make_item(MODE_ADD, 0, 0, 32'h0));

      // Random phases: loads mostly in range, then a few computes
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_until_idle(SETTLE_CYCLES);
         case (phase % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 46; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 46; end
            default: begin req_idle_pct = 15; rsp_stall_pct = 15; end
         endcase
         shape = $urandom_range(0, 5);
         case (shape)
            0, 1: begin
               sz_ar = CFG_W'($urandom_range(1, 4));
               sz_ac = sz_ar;
               sz_br = sz_ar;
               sz_bc = sz_ar;
            end
            2, 3: begin
               sz_ar = CFG_W'($urandom_range(1, 4));
               sz_ac = CFG_W'($urandom_range(0, 4));
               sz_br = sz_ac;
               sz_bc = CFG_W'($urandom_range(1, 4));
            end
            4: begin
               sz_ar = CFG_W'($urandom_range(0, 15));
               sz_ac = CFG_W'($urandom_range(0, 15));
               sz_br = CFG_W'($urandom_range(0, 15));
               sz_bc = CFG_W'($urandom_range(0, 15));
            end
            default: begin
               sz_ar = CFG_W'(MAX_DIM_DEF);
               sz_ac = CFG_W'(MAX_DIM_DEF);
               sz_br = CFG_W'(MAX_DIM_DEF);
               sz_bc = CFG_W'(MAX_DIM_DEF);
            end
         endcase
         set_sizes(sz_ar, sz_ac, sz_br, sz_bc);
         n_compute = $urandom_range(1, 3);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i >= ITEMS_PER_PHASE - n_compute) begin
               item = make_item($urandom_range(0, 1) ? MODE_MUL : MODE_ADD,
                                $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
            end else begin
               to_b        = $urandom_range(0, 1);
               rows_in_use = to_b ? int'(sz_br) : int'(sz_ar);
               cols_in_use = to_b ? int'(sz_bc) : int'(sz_ac);
               if (rows_in_use > MAX_DIM_DEF) rows_in_use = MAX_DIM_DEF;
               if (cols_in_use > MAX_DIM_DEF) cols_in_use = MAX_DIM_DEF;
               // Mostly in range; now and then anywhere in the index space
               if (rows_in_use == 0 || cols_in_use == 0 || $urandom_range(0, 7) == 0) begin
                  row = $urandom_range(0, 7);
                  col = $urandom_range(0, 7);
               end else begin
                  row = $urandom_range(0, rows_in_use - 1);
                  col = $urandom_range(0, cols_in_use - 1);
               end
               case ($urandom_range(0, 7))
                  0: value = 32'h8000_0000;
                  1: value = 32'h7FFF_FFFF;
                  2: value = 32'hFFFF_FFFF;
                  3: value = 32'h0000_0000;
                  default: value = $urandom;
               endcase
               item = make_item(to_b ? MODE_LOAD_B : MODE_LOAD_A, row, col, value);
            end
            send_req(item);
         end
      end

      wait_until_idle(END_CYCLES);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/mae_pkg.sv
rtl/mae_ram.sv
rtl/mae_mac.sv
rtl/matrix_add_multiply_engine_top.sv
rtl/mae_checker.sv
tb/matrix_result_checker.sv
tb/tb.sv
